@@ rtl/xpt_pkg.sv @@
package xpt_pkg;

   localparam int VIRT_PAGES_DEF = 256;
   localparam int PHYS_PAGES_DEF = 512;
   localparam int PPN_W = 9;
   localparam int ENTRY_W = PPN_W + 1;
   localparam logic [31:0] MAP_BASE_RST = 32'h4200_0000;
   localparam logic [16:0] FULL_PAGE = 17'd65536;

   typedef enum logic [2:0] {
      FUNC_READ  = 3'd0,
      FUNC_WRITE = 3'd1,
      FUNC_MAP   = 3'd2,
      FUNC_UNMAP = 3'd3,
      FUNC_FIND  = 3'd4
   } func_type;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_BAD_INDEX = 4'd1,
      ST_BAD_VIRT  = 4'd2,
      ST_BAD_PHYS  = 4'd3,
      ST_BAD_LEN   = 4'd4,
      ST_OFFSET    = 4'd5,
      ST_OVERLAP   = 4'd6,
      ST_NOT_EN    = 4'd7,
      ST_NONE_FREE = 4'd8
   } status_type;

   typedef enum logic {
      CSR_PAGE_SIZE = 1'b0,
      CSR_MAP_BASE  = 1'b1
   } csr_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_CHECK, S_SCAN, S_SCAN_WAIT,
      S_FILL, S_FIND, S_FIND_WAIT, S_READ_WAIT, S_RESULT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic clr_start;
      logic scan_start;
      logic fill_start;
      logic find_start;
      logic step;
      logic rd_issue;
      logic wr_en;
      logic wr_clear;
      logic fill_valid;
      logic set_result;
      logic [3:0] status;
      logic ok;
      logic rsp_load;
   } ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic [2:0] func;
      logic idx_bad;
      logic wr_en_req;
      logic [3:0] wr_err;
      logic [3:0] map_err;
      logic unmap_bad;
      logic allow_ov;
      logic walk_done;
      logic rd_valid;
      logic clr_done;
   } sts_type;

endpackage

@@ rtl/xpt_stream_if.sv @@
interface xpt_stream_if #(parameter int W = 8);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/xpt_ctrl.sv @@
module xpt_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic rsp_busy,
   input  xpt_pkg::sts_type sts,
   output xpt_pkg::ctl_type ctl
);

   xpt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xpt_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         xpt_pkg::S_CLEAR: begin
            ctl.wr_en = 1'b1;
            ctl.wr_clear = 1'b1;
            ctl.step = 1'b1;
            if (sts.clr_done) begin
               state_in = xpt_pkg::S_IDLE;
            end
         end
         xpt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = xpt_pkg::S_DECODE;
            end
         end
         xpt_pkg::S_DECODE: begin
            state_in = xpt_pkg::S_RESULT;
            unique case (sts.func)
               xpt_pkg::FUNC_READ: begin
                  if (sts.idx_bad) begin
                     ctl.set_result = 1'b1;
                     ctl.status = xpt_pkg::ST_BAD_INDEX;
                  end else begin
                     ctl.rd_issue = 1'b1;
                     state_in = xpt_pkg::S_READ_WAIT;
                  end
               end
               xpt_pkg::FUNC_WRITE: begin
                  ctl.set_result = 1'b1;
                  if (sts.idx_bad) begin
                     ctl.status = xpt_pkg::ST_BAD_INDEX;
                  end else if (!sts.wr_en_req) begin
                     ctl.ok = 1'b1;
                     ctl.wr_en = 1'b1;
                     ctl.wr_clear = 1'b1;
                  end else if (sts.wr_err != xpt_pkg::ST_OK) begin
                     ctl.status = sts.wr_err;
                  end else begin
                     ctl.ok = 1'b1;
                     ctl.wr_en = 1'b1;
                  end
               end
               xpt_pkg::FUNC_MAP, xpt_pkg::FUNC_UNMAP: begin
                  state_in = xpt_pkg::S_CHECK;
               end
               xpt_pkg::FUNC_FIND: begin
                  ctl.find_start = 1'b1;
                  state_in = xpt_pkg::S_FIND;
               end
               default: begin
                  ctl.set_result = 1'b1;
               end
            endcase
         end
         xpt_pkg::S_CHECK: begin
            if (sts.func == xpt_pkg::FUNC_UNMAP) begin
               if (sts.unmap_bad) begin
                  ctl.set_result = 1'b1;
                  ctl.status = xpt_pkg::ST_BAD_VIRT;
                  state_in = xpt_pkg::S_RESULT;
               end else begin
                  ctl.fill_start = 1'b1;
                  state_in = xpt_pkg::S_FILL;
               end
            end else if (sts.map_err != xpt_pkg::ST_OK) begin
               ctl.set_result = 1'b1;
               ctl.status = sts.map_err;
               state_in = xpt_pkg::S_RESULT;
            end else if (sts.allow_ov) begin
               ctl.fill_start = 1'b1;
               state_in = xpt_pkg::S_FILL;
            end else begin
               ctl.scan_start = 1'b1;
               state_in = xpt_pkg::S_SCAN;
            end
         end
         xpt_pkg::S_SCAN: begin
            if (sts.walk_done) begin
               ctl.fill_start = 1'b1;
               state_in = xpt_pkg::S_FILL;
            end else begin
               ctl.rd_issue = 1'b1;
               state_in = xpt_pkg::S_SCAN_WAIT;
            end
         end
         xpt_pkg::S_SCAN_WAIT: begin
            if (sts.rd_valid) begin
               ctl.set_result = 1'b1;
               ctl.status = xpt_pkg::ST_OVERLAP;
               state_in = xpt_pkg::S_RESULT;
            end else begin
               ctl.step = 1'b1;
               state_in = xpt_pkg::S_SCAN;
            end
         end
         xpt_pkg::S_FILL: begin
            if (sts.walk_done) begin
               ctl.set_result = 1'b1;
               ctl.ok = 1'b1;
               state_in = xpt_pkg::S_RESULT;
            end else begin
               ctl.wr_en = 1'b1;
               ctl.wr_clear = (sts.func == xpt_pkg::FUNC_UNMAP);
               ctl.fill_valid = 1'b1;
               ctl.step = 1'b1;
            end
         end
         xpt_pkg::S_FIND: begin
            if (sts.walk_done) begin
               ctl.set_result = 1'b1;
               ctl.status = xpt_pkg::ST_NONE_FREE;
               state_in = xpt_pkg::S_RESULT;
            end else begin
               ctl.rd_issue = 1'b1;
               state_in = xpt_pkg::S_FIND_WAIT;
            end
         end
         xpt_pkg::S_FIND_WAIT: begin
            if (!sts.rd_valid) begin
               ctl.set_result = 1'b1;
               ctl.ok = 1'b1;
               state_in = xpt_pkg::S_RESULT;
            end else begin
               ctl.step = 1'b1;
               state_in = xpt_pkg::S_FIND;
            end
         end
         xpt_pkg::S_READ_WAIT: begin
            ctl.set_result = 1'b1;
            ctl.ok = 1'b1;
            state_in = xpt_pkg::S_RESULT;
         end
         xpt_pkg::S_RESULT: begin
            if (!rsp_busy) begin
               ctl.rsp_load = 1'b1;
               state_in = xpt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = xpt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/xpt_datapath.sv @@
module xpt_datapath #(
   parameter int VIRT_PAGES = xpt_pkg::VIRT_PAGES_DEF,
   parameter int PHYS_PAGES = xpt_pkg::PHYS_PAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic [1:0] page_size_code,
   input  logic [31:0] map_base,
   input  logic [2:0] req_func,
   input  logic [9:0] req_entry_index,
   input  logic [31:0] req_virt_addr,
   input  logic [31:0] req_phys_addr,
   input  logic [31:0] req_span_length,
   input  logic req_entry_enable,
   input  logic req_allow_overlap,
   input  xpt_pkg::ctl_type ctl,
   output xpt_pkg::sts_type sts,
   output logic res_ok,
   output logic [3:0] res_status,
   output logic [24:0] res_phys_addr,
   output logic [31:0] res_virt_addr,
   output logic [16:0] res_length,
   output logic res_enable
);

   localparam int IW = $clog2(VIRT_PAGES);
   localparam int CW = IW + 1;
   localparam logic [CW-1:0] VP = CW'(VIRT_PAGES);

   logic [xpt_pkg::ENTRY_W-1:0] table_mem [VIRT_PAGES];
   logic [xpt_pkg::ENTRY_W-1:0] rd_data_ff;

   logic [2:0] func_ff;
   logic [9:0] idx_ff;
   logic [31:0] virt_ff, phys_ff, len_ff;
   logic en_ff, ov_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] last_ff;
   logic [xpt_pkg::PPN_W-1:0] ppn_ff;

   logic [16:0] psize;
   logic [4:0] sh;
   logic [32:0] off;
   logic [33:0] vend, wend, pend, plim, last_num;
   logic [CW-1:0] first_pg, last_pg;
   logic [31:0] exp_virt, idx_mul;
   logic [22:0] phys_pg;
   logic [15:0] pmask;

   assign psize = xpt_pkg::FULL_PAGE >> page_size_code;
   assign sh = 5'd16 - 5'(page_size_code);
   assign pmask = 16'(psize - 17'd1);
   assign idx_mul = 32'(idx_ff) << sh;
   assign exp_virt = map_base + idx_mul;
   assign phys_pg = 23'(phys_ff >> sh);

   assign off = {1'b0, virt_ff} - {1'b0, map_base};
   assign vend = {2'b0, virt_ff} + {2'b0, len_ff};
   assign wend = {2'b0, map_base} + (34'(VIRT_PAGES) << sh);
   assign pend = {2'b0, phys_ff} + {2'b0, len_ff};
   assign plim = 34'(PHYS_PAGES) << sh;
   assign last_num = {1'b0, off} + {2'b0, len_ff} + 34'(pmask);
   assign first_pg = ((off >> sh) > 33'(VIRT_PAGES)) ? VP : CW'(off >> sh);
   assign last_pg = ((last_num >> sh) > 34'(VIRT_PAGES)) ? VP : CW'(last_num >> sh);

   logic range_bad;
   assign range_bad = (virt_ff < map_base) || (vend > wend);

   always_comb begin
      sts = '0;
      sts.func = func_ff;
      sts.idx_bad = ({1'b0, idx_ff} >= 11'(VIRT_PAGES));
      sts.wr_en_req = en_ff;
      if (virt_ff != exp_virt) begin
         sts.wr_err = xpt_pkg::ST_BAD_VIRT;
      end else if ((phys_ff[15:0] & pmask) != 16'd0) begin
         sts.wr_err = xpt_pkg::ST_BAD_PHYS;
      end else if (phys_pg >= 23'(PHYS_PAGES)) begin
         sts.wr_err = xpt_pkg::ST_BAD_PHYS;
      end else if (len_ff != 32'(psize)) begin
         sts.wr_err = xpt_pkg::ST_BAD_LEN;
      end else begin
         sts.wr_err = xpt_pkg::ST_OK;
      end
      if (!en_ff) begin
         sts.map_err = xpt_pkg::ST_NOT_EN;
      end else if (range_bad) begin
         sts.map_err = xpt_pkg::ST_BAD_VIRT;
      end else if (pend > plim) begin
         sts.map_err = xpt_pkg::ST_BAD_PHYS;
      end else if ((phys_ff[15:0] & pmask) != (virt_ff[15:0] & pmask)) begin
         sts.map_err = xpt_pkg::ST_OFFSET;
      end else begin
         sts.map_err = xpt_pkg::ST_OK;
      end
      sts.unmap_bad = range_bad;
      sts.allow_ov = ov_ff;
      sts.walk_done = (func_ff == xpt_pkg::FUNC_FIND) ? (cnt_ff == VP) : (cnt_ff >= last_ff);
      sts.rd_valid = rd_data_ff[xpt_pkg::ENTRY_W-1];
      sts.clr_done = (cnt_ff == VP - CW'(1));
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         func_ff <= req_func;
         idx_ff <= req_entry_index;
         virt_ff <= req_virt_addr;
         phys_ff <= req_phys_addr;
         len_ff <= req_span_length;
         en_ff <= req_entry_enable;
         ov_ff <= req_allow_overlap;
      end
   end

   // The find walk counts up and addresses the entries from the top one down.
   logic [IW-1:0] find_idx;
   assign find_idx = IW'(VP - CW'(1) - cnt_ff);

   logic [IW-1:0] addr;
   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.scan_start || ctl.fill_start) begin
         cnt_in = first_pg;
      end else if (ctl.find_start) begin
         cnt_in = '0;
      end else if (ctl.step) begin
         cnt_in = cnt_ff + CW'(1);
      end
      if (ctl.rd_issue || ctl.wr_en) begin
         if (func_ff == xpt_pkg::FUNC_FIND) begin
            addr = find_idx;
         end else if (ctl.fill_valid) begin
            addr = cnt_ff[IW-1:0];
         end else if (func_ff == xpt_pkg::FUNC_MAP) begin
            addr = cnt_ff[IW-1:0];
         end else begin
            addr = idx_ff[IW-1:0];
         end
      end else begin
         addr = cnt_ff[IW-1:0];
      end
   end

   logic clearing;
   assign clearing = ctl.wr_clear && ctl.step && !ctl.fill_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      if (ctl.scan_start || ctl.fill_start) begin
         last_ff <= last_pg;
         ppn_ff <= phys_pg[xpt_pkg::PPN_W-1:0];
      end else if (ctl.fill_valid) begin
         ppn_ff <= ppn_ff + xpt_pkg::PPN_W'(1);
      end
   end

   logic [IW-1:0] wr_addr;
   assign wr_addr = clearing ? cnt_ff[IW-1:0] : addr;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         if (ctl.wr_clear) begin
            table_mem[wr_addr] <= '0;
         end else if (ctl.fill_valid) begin
            table_mem[wr_addr] <= {1'b1, ppn_ff};
         end else begin
            table_mem[wr_addr] <= {1'b1, phys_pg[xpt_pkg::PPN_W-1:0]};
         end
      end
      if (ctl.rd_issue) begin
         rd_data_ff <= table_mem[addr];
      end
   end

   logic [31:0] find_virt;
   assign find_virt = map_base + (32'(find_idx) << sh);

   always_ff @(posedge clock) begin
      if (ctl.set_result) begin
         res_ok <= ctl.ok;
         res_status <= ctl.status;
         res_phys_addr <= '0;
         res_virt_addr <= '0;
         res_length <= '0;
         res_enable <= 1'b0;
         if (ctl.ok && func_ff == xpt_pkg::FUNC_READ) begin
            res_phys_addr <= 25'(rd_data_ff[xpt_pkg::PPN_W-1:0]) << sh;
            res_virt_addr <= exp_virt;
            res_length <= psize;
            res_enable <= rd_data_ff[xpt_pkg::ENTRY_W-1];
         end else if (ctl.ok && func_ff == xpt_pkg::FUNC_FIND) begin
            res_virt_addr <= find_virt;
         end
      end
   end

endmodule

@@ rtl/xip_page_table_manager_unit.sv @@
// A write or unused operation answers from decode, a read after its table read, a failed range
// check after the check. Unmap, and map without the overlap check, write each page of the span;
// a checked map first reads each page (overlap if one is enabled), then writes them; a find
// reads entries from the top down. One operation at a time: the next request is taken in the
// cycle after the response is loaded. After reset a clearing pass zeroes the table while
// requests wait. Reset is synchronous and active high; configuration returns to reset values.
module xip_page_table_manager_unit #(
   parameter int VIRT_PAGES = xpt_pkg::VIRT_PAGES_DEF,
   parameter int PHYS_PAGES = xpt_pkg::PHYS_PAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   xpt_stream_if.sink req,
   xpt_stream_if.source rsp,
   input  logic csr_write_enable,
   input  logic csr_index,
   input  logic [31:0] csr_write_data
);

   logic [1:0] psc_ff;
   logic [31:0] base_ff;
   logic rsp_valid_ff;
   xpt_pkg::ctl_type ctl;
   xpt_pkg::sts_type sts;
   logic r_ok, r_en;
   logic [3:0] r_st;
   logic [24:0] r_pa;
   logic [31:0] r_va;
   logic [16:0] r_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         psc_ff <= '0;
         base_ff <= xpt_pkg::MAP_BASE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               xpt_pkg::CSR_PAGE_SIZE: psc_ff <= csr_write_data[1:0];
               xpt_pkg::CSR_MAP_BASE: base_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (ctl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   xpt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .rsp_busy(rsp_valid_ff && !rsp.ready), .sts(sts), .ctl(ctl)
   );

   xpt_datapath #(.VIRT_PAGES(VIRT_PAGES), .PHYS_PAGES(PHYS_PAGES)) u_dp (
      .clock(clock), .reset(reset), .page_size_code(psc_ff), .map_base(base_ff),
      .req_func(req.data[2:0]), .req_entry_index(req.data[12:3]),
      .req_virt_addr(req.data[44:13]), .req_phys_addr(req.data[76:45]),
      .req_span_length(req.data[108:77]), .req_entry_enable(req.data[109]),
      .req_allow_overlap(req.data[110]), .ctl(ctl), .sts(sts),
      .res_ok(r_ok), .res_status(r_st), .res_phys_addr(r_pa), .res_virt_addr(r_va),
      .res_length(r_len), .res_enable(r_en)
   );

   logic [79:0] rsp_data_ff;
   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_data_ff <= {r_en, r_len, r_va, r_pa, r_st, r_ok};
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_data_ff;

endmodule
